FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the tilt filter checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define TCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tilt filter check failed");

// next-cycle implication, held off during reset
`define TCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tilt filter check failed");

`endif

FILE: rtl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// shared types, constants and the cordic arctangent table of the tilt filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcf_pkg;

  // cordic iteration count, limited by the table length
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_TBL_LEN      = 24;
  localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS > ATAN_TBL_LEN) ?
                                     ATAN_TBL_LEN : CORDIC_ITERATIONS;
  localparam int TBL_IDX_W         = $clog2(ATAN_TBL_LEN);
  localparam int ATAN_W            = 22;

  // gyro increment: rounded quotient of |num| / 256e6, with 256e6 = 2^14 * 15625;
  // (|num| + half) >> 14 is multiplied by ceil(2^47 / 15625) and shifted by 47
  localparam int  DIV_Q_BITS   = 21;
  localparam int  DIV_W        = 48;
  localparam int  DIV_STEPS    = 2;
  localparam logic [DIV_W-1:0] GYRO_DIV_HALF = DIV_W'(128000000);
  localparam logic [33:0]      GYRO_RECIP    = 34'd9007199255;

  // back end sequencing
  localparam int RUN_STEPS = (CORDIC_STEPS > DIV_STEPS) ? CORDIC_STEPS : DIV_STEPS;

  // angle limits and constants
  localparam int ANGLE_LIMIT    = 184320;
  localparam int ACC_MAX_Q16    = 92160 * 256;
  localparam int ACC_ZERO_ANGLE = 46080;
  localparam int ONE_Q16        = 65536;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_GAIN    = 1'd1;

  // quadrant base of the accelerometer angle
  localparam logic [1:0] BASE_ZERO = 2'd0;
  localparam logic [1:0] BASE_HALF = 2'd1;
  localparam logic [1:0] BASE_FULL = 2'd2;

  typedef struct packed {
    logic signed [15:0] gyro;
    logic        [15:0] dt;
    logic signed [16:0] x0;
    logic signed [16:0] y0;
    logic        [1:0]  base;
    logic               zero;
  } tcf_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } tcf_qstat_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [TBL_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/tcf_queue.sv
// ----------------------------------------------------------------------------
// tcf_queue
// short request queue between the classifying front and the compute back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  tcf_pkg::tcf_item_t  wr_item,
  input  logic                rd_en,
  output tcf_pkg::tcf_item_t  rd_item,
  output tcf_pkg::tcf_qstat_t stat
);

  localparam int PTR_W = (tcf_pkg::QUEUE_DEPTH > 1) ? $clog2(tcf_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(tcf_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(tcf_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(tcf_pkg::QUEUE_DEPTH);

  tcf_pkg::tcf_item_t mem_r [tcf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == CNT_FULL);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_item    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

FILE: rtl/tcf_front.sv
// ----------------------------------------------------------------------------
// tcf_front
// takes imu samples and sorts them by accelerometer quadrant
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcf_front (
  input  logic                      push,
  output logic                      full,
  input  logic signed [15:0]        gyro_rate_raw,
  input  logic signed [15:0]        accel_x_raw,
  input  logic signed [15:0]        accel_z_raw,
  input  logic        [15:0]        step_time_us,
  input  tcf_pkg::tcf_qstat_t       q_stat,
  output logic                      q_wr,
  output tcf_pkg::tcf_item_t        q_item
);

  logic signed [16:0] ax_ext, az_ext;

  assign ax_ext = 17'(accel_x_raw);
  assign az_ext = 17'(accel_z_raw);
  assign full   = q_stat.full;
  assign q_wr   = push && !q_stat.full;

  always_comb begin
    q_item.gyro = gyro_rate_raw;
    q_item.dt   = step_time_us;
    q_item.zero = (accel_x_raw == 16'sd0) && (accel_z_raw == 16'sd0);
    // left half plane: rotate by 180 degrees so the cordic starts with x >= 0
    if (accel_x_raw < 16'sd0) begin
      q_item.x0   = -ax_ext;
      q_item.y0   = -az_ext;
      q_item.base = (accel_z_raw >= 16'sd0) ? tcf_pkg::BASE_FULL : tcf_pkg::BASE_ZERO;
    end else begin
      q_item.x0   = ax_ext;
      q_item.y0   = az_ext;
      q_item.base = tcf_pkg::BASE_HALF;
    end
  end

endmodule

FILE: rtl/tcf_back.sv
// ----------------------------------------------------------------------------
// tcf_back
// cordic tilt angle, gyro increment reciprocal multiply, blend and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tcf_pkg::tcf_qstat_t q_stat,
  input  tcf_pkg::tcf_item_t  q_item,
  output logic                q_rd,
  input  logic [16:0]         blend_weight,
  input  logic [15:0]         gyro_gain,
  output logic                empty,
  input  logic                pop,
  output logic signed [18:0]  filtered_angle,
  output logic        [16:0]  accel_angle
);

  localparam int XY_W  = 33;
  localparam int Z_W   = 26;
  localparam int TOT_W = 27;
  localparam int CNT_W = $clog2(tcf_pkg::RUN_STEPS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(tcf_pkg::RUN_STEPS - 1);
  localparam logic [CNT_W-1:0] CNT_CORDIC = CNT_W'(tcf_pkg::CORDIC_STEPS);
  localparam logic [16:0] ONE17 = 17'(tcf_pkg::ONE_Q16);
  localparam logic signed [TOT_W-1:0] ACC_MAX = TOT_W'(tcf_pkg::ACC_MAX_Q16);
  localparam logic signed [25:0] LIM_HI = 26'(tcf_pkg::ANGLE_LIMIT);
  localparam logic signed [25:0] LIM_LO = -26'(tcf_pkg::ANGLE_LIMIT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_BL1  = 3'd5;
  localparam logic [2:0] S_BL2  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic signed [15:0]          gyro_r, gyro_nxt;
  logic        [15:0]          dt_r, dt_nxt;
  logic        [1:0]           base_r, base_nxt;
  logic                        zero_r, zero_nxt;
  logic signed [XY_W-1:0]      x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]       z_r, z_nxt;
  logic signed [32:0]          p1_r, p1_nxt;
  logic                        neg_r, neg_nxt;
  logic [tcf_pkg::DIV_W-1:0]   mag_r, mag_nxt;
  logic [49:0]                 ph_r, ph_nxt;
  logic [50:0]                 pl_r, pl_nxt;
  logic [tcf_pkg::DIV_Q_BITS-1:0] quo_r, quo_nxt;
  logic [16:0]                 acc_r, acc_nxt;
  logic signed [22:0]          pred_r, pred_nxt;
  logic signed [40:0]          pa_r, pa_nxt;
  logic signed [41:0]          sum_r, sum_nxt;
  logic signed [18:0]          kept_r, kept_nxt;
  logic                        ovld_r, ovld_nxt;
  logic signed [18:0]          ofilt_r, ofilt_nxt;
  logic [16:0]                 oacc_r, oacc_nxt;

  logic [16:0]                 a_eff;
  logic signed [XY_W-1:0]      xs, ys;
  logic signed [Z_W-1:0]       z_step;
  logic signed [49:0]          p2;
  logic [tcf_pkg::DIV_W-1:0]   p2_mag;
  logic signed [TOT_W-1:0]     base_val, total, tot_cl;
  logic [TOT_W-1:0]            tot_rnd;
  logic signed [21:0]          delta;
  logic [33:0]                 oma_prod;
  logic signed [41:0]          rnd_sum;
  logic signed [25:0]          res_full;
  logic signed [18:0]          res_sat;
  logic                        out_free;

  assign a_eff    = (blend_weight > ONE17) ? ONE17 : blend_weight;
  assign xs       = x_r >>> cnt_r;
  assign ys       = y_r >>> cnt_r;
  assign z_step   = $signed({{(Z_W - tcf_pkg::ATAN_W){1'b0}},
                             tcf_pkg::atan_q16(tcf_pkg::TBL_IDX_W'(cnt_r))});
  assign p2       = p1_r * $signed({1'b0, dt_r});
  assign p2_mag   = p2[49] ? tcf_pkg::DIV_W'(-p2) : p2[tcf_pkg::DIV_W-1:0];
  assign total    = base_val + TOT_W'(z_r);
  assign tot_rnd  = TOT_W'(tot_cl) + TOT_W'(128);
  assign delta    = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign oma_prod = (ONE17 - a_eff) * acc_r;
  assign rnd_sum  = sum_r + 42'sd32768;
  assign res_full = rnd_sum[41:16];
  assign out_free = !ovld_r || pop;

  assign q_rd           = (state_r == S_IDLE) && !q_stat.empty;
  assign empty          = !ovld_r;
  assign filtered_angle = ofilt_r;
  assign accel_angle    = oacc_r;

  always_comb begin
    case (base_r)
      tcf_pkg::BASE_HALF: base_val = TOT_W'(180 * 65536);
      tcf_pkg::BASE_FULL: base_val = TOT_W'(360 * 65536);
      default:            base_val = '0;
    endcase
    if (total < 0) begin
      tot_cl = '0;
    end else if (total > ACC_MAX) begin
      tot_cl = ACC_MAX;
    end else begin
      tot_cl = total;
    end
    if (res_full > LIM_HI) begin
      res_sat = LIM_HI[18:0];
    end else if (res_full < LIM_LO) begin
      res_sat = LIM_LO[18:0];
    end else begin
      res_sat = res_full[18:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    gyro_nxt  = gyro_r;
    dt_nxt    = dt_r;
    base_nxt  = base_r;
    zero_nxt  = zero_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    p1_nxt    = p1_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    ph_nxt    = ph_r;
    pl_nxt    = pl_r;
    quo_nxt   = quo_r;
    acc_nxt   = acc_r;
    pred_nxt  = pred_r;
    pa_nxt    = pa_r;
    sum_nxt   = sum_r;
    kept_nxt  = kept_r;
    ovld_nxt  = ovld_r;
    ofilt_nxt = ofilt_r;
    oacc_nxt  = oacc_r;

    if (pop && ovld_r) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          gyro_nxt  = q_item.gyro;
          dt_nxt    = q_item.dt;
          base_nxt  = q_item.base;
          zero_nxt  = q_item.zero;
          x_nxt     = XY_W'(q_item.x0) <<< 14;
          y_nxt     = XY_W'(q_item.y0) <<< 14;
          z_nxt     = '0;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        p1_nxt    = gyro_r * $signed({1'b0, gyro_gain});
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        neg_nxt   = p2[49];
        mag_nxt   = p2_mag + tcf_pkg::GYRO_DIV_HALF;
        cnt_nxt   = '0;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        // vectoring cordic step
        if (cnt_r < CNT_CORDIC) begin
          if (!y_r[XY_W-1]) begin
            x_nxt = x_r + ys;
            y_nxt = y_r - xs;
            z_nxt = z_r + z_step;
          end else begin
            x_nxt = x_r - ys;
            y_nxt = y_r + xs;
            z_nxt = z_r - z_step;
          end
        end
        // quotient of (mag >> 14) / 15625 by reciprocal, split into 16 and 17 bit halves;
        // the products settle in the first step and the quotient in the second
        ph_nxt  = 50'(mag_r[46:31]) * 50'(tcf_pkg::GYRO_RECIP);
        pl_nxt  = 51'(mag_r[30:14]) * 51'(tcf_pkg::GYRO_RECIP);
        quo_nxt = tcf_pkg::DIV_Q_BITS'(({1'b0, ph_r} + 51'(pl_r[50:17])) >> 30);
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_ACC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ACC: begin
        acc_nxt   = zero_r ? 17'(tcf_pkg::ACC_ZERO_ANGLE) : tot_rnd[24:8];
        pred_nxt  = 23'(kept_r) + 23'(delta);
        state_nxt = S_BL1;
      end
      S_BL1: begin
        pa_nxt    = $signed({1'b0, a_eff}) * pred_r;
        state_nxt = S_BL2;
      end
      S_BL2: begin
        sum_nxt   = 42'(pa_r) + $signed({8'd0, oma_prod});
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          kept_nxt  = res_sat;
          ofilt_nxt = res_sat;
          oacc_nxt  = acc_r;
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kept_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kept_r  <= kept_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    gyro_r  <= gyro_nxt;
    dt_r    <= dt_nxt;
    base_r  <= base_nxt;
    zero_r  <= zero_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    p1_r    <= p1_nxt;
    neg_r   <= neg_nxt;
    mag_r   <= mag_nxt;
    ph_r    <= ph_nxt;
    pl_r    <= pl_nxt;
    quo_r   <= quo_nxt;
    acc_r   <= acc_nxt;
    pred_r  <= pred_nxt;
    pa_r    <= pa_nxt;
    sum_r   <= sum_nxt;
    ofilt_r <= ofilt_nxt;
    oacc_r  <= oacc_nxt;
  end

endmodule

FILE: rtl/tilt_complementary_filter.sv
// ----------------------------------------------------------------------------
// tilt_complementary_filter
// one-axis imu tilt estimate from gyro rate and accelerometer x/z
// ----------------------------------------------------------------------------
// Each sample pushed in yields exactly one result: the accelerometer angle
// atan2(z, x) + 180 degrees (0..360 degrees, 1/256 degree units, from a
// vectoring cordic) and the filtered angle a * (kept + gyro * gain * dt) +
// (1 - a) * accel_angle, saturated at +-720 degrees and kept for the next
// sample. The back end takes one sample at a time and steps it through the
// multiply states, the cordic loop at one iteration per cycle, accumulate,
// two blend states and done, which waits while a result is still held; the
// gyro increment is divided by a reciprocal multiplication inside the loop.
// A two-entry request queue sits in front of the back end and a result
// register behind it, so up to two samples can be pushed while one is being
// computed and one result waits to be popped.
// Registers must be written through the cfg port while the block is idle,
// not enforced by the block; blend_weight (index 0, Q1.16, values above
// one act as one) and gyro_gain (index 1, Q0.16 degrees per second per lsb).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tilt_complementary_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample request channel
  input  logic                                push,
  output logic                                full,
  input  logic signed [15:0]                  in_gyro_rate_raw,
  input  logic signed [15:0]                  in_accel_x_raw,
  input  logic signed [15:0]                  in_accel_z_raw,
  input  logic        [15:0]                  in_step_time_us,
  // result channel
  output logic                                empty,
  input  logic                                pop,
  output logic signed [18:0]                  out_filtered_angle,
  output logic        [16:0]                  out_accel_angle,
  // register write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [16:0]                         cfg_data
);

  // configuration registers
  logic [16:0] blend_weight_r, blend_weight_nxt;
  logic [15:0] gyro_gain_r, gyro_gain_nxt;

  // front to queue to back
  tcf_pkg::tcf_item_t  fq_item, qb_item;
  tcf_pkg::tcf_qstat_t q_stat;
  logic                fq_wr, qb_rd;

  // writes are always accepted
  assign cfg_ready = 1'b1;

  always_comb begin
    blend_weight_nxt = blend_weight_r;
    gyro_gain_nxt    = gyro_gain_r;
    if (cfg_valid) begin
      case (cfg_index)
        tcf_pkg::REG_BLEND_WEIGHT: blend_weight_nxt = cfg_data;
        tcf_pkg::REG_GYRO_GAIN:    gyro_gain_nxt    = cfg_data[15:0];
        default: begin
          blend_weight_nxt = blend_weight_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_weight_r <= 17'd32768;
      gyro_gain_r    <= 16'd4588;
    end else begin
      blend_weight_r <= blend_weight_nxt;
      gyro_gain_r    <= gyro_gain_nxt;
    end
  end

  // quadrant sort and request acceptance
  tcf_front u_front (
    .push          (push),
    .full          (full),
    .gyro_rate_raw (in_gyro_rate_raw),
    .accel_x_raw   (in_accel_x_raw),
    .accel_z_raw   (in_accel_z_raw),
    .step_time_us  (in_step_time_us),
    .q_stat        (q_stat),
    .q_wr          (fq_wr),
    .q_item        (fq_item)
  );

  // decouples sample arrival from the compute loop
  tcf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_wr),
    .wr_item (fq_item),
    .rd_en   (qb_rd),
    .rd_item (qb_item),
    .stat    (q_stat)
  );

  // cordic, gyro increment, blend, kept angle and result register
  tcf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_item         (qb_item),
    .q_rd           (qb_rd),
    .blend_weight   (blend_weight_r),
    .gyro_gain      (gyro_gain_r),
    .empty          (empty),
    .pop            (pop),
    .filtered_angle (out_filtered_angle),
    .accel_angle    (out_accel_angle)
  );

endmodule

FILE: rtl/tcf_checker.sv
// ----------------------------------------------------------------------------
// tcf_checker
// port-level checks on the tilt filter result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               empty,
  input logic               pop,
  input logic signed [18:0] out_filtered_angle,
  input logic        [16:0] out_accel_angle
);

  logic        filt_in_range;
  logic        res_wait;
  logic [35:0] res_word;

  assign filt_in_range = (out_filtered_angle <= 19'sd184320) &&
                         (out_filtered_angle >= -19'sd184320);
  assign res_wait      = !empty && !pop;
  assign res_word      = {out_filtered_angle, out_accel_angle};

  // accel angle never leaves 0..360 degrees
  `TCF_ASSERT_IMP(a_acc_range, clk, rst_n, !empty, out_accel_angle <= 17'd92160)

  // filtered angle stays inside the saturation limits
  `TCF_ASSERT_IMP(a_filt_range, clk, rst_n, !empty, filt_in_range)

  // a waiting result is not dropped
  `TCF_ASSERT_NXT(a_res_hold, clk, rst_n, res_wait, !empty)

  // a waiting result does not change
  `TCF_ASSERT_NXT(a_res_stable, clk, rst_n, res_wait, $stable(res_word))

endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .empty              (empty),
  .pop                (pop),
  .out_filtered_angle (out_filtered_angle),
  .out_accel_angle    (out_accel_angle)
);

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the one-axis tilt complementary filter
// ----------------------------------------------------------------------------
// Samples are pushed through the request queue while results are popped on
// the other side, both with random stall bursts in all but the last phase.
// Every accepted request is run through a local fixed-point model of the
// cordic accelerometer angle and the gyro/accelerometer blend, and the
// expected result is queued. Each popped result is compared field by field
// with the oldest queued one. Directed requests cover the field extremes,
// the accelerometer special cases, blend weights of zero, one and above one,
// and filter saturation, then random phases under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  // idle cycles after the last result before registers are touched
  localparam int SETTLE_CYCLES   = 40;
  // cap on the final wait for outstanding results
  localparam int END_WAIT_LIMIT  = 5000;
  localparam int ITEMS_PER_PHASE = 100;

  typedef struct packed {
    logic signed [18:0] filtered_angle;
    logic        [16:0] accel_angle;
  } tilt_result_t;

  // dut side signals, inputs driven to known values from time zero
  logic               clk                = 1'b0;
  logic               rst_n              = 1'b0;
  logic               push               = 1'b0;
  logic signed [15:0] in_gyro_rate_raw   = '0;
  logic signed [15:0] in_accel_x_raw     = '0;
  logic signed [15:0] in_accel_z_raw     = '0;
  logic        [15:0] in_step_time_us    = '0;
  logic               pop                = 1'b0;
  logic               cfg_valid          = 1'b0;
  logic [tcf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic        [16:0] cfg_data           = '0;
  logic               full;
  logic               empty;
  logic               cfg_ready;
  logic signed [18:0] out_filtered_angle;
  logic        [16:0] out_accel_angle;

  // model state and register copies, reset values of the block
  longint             model_kept_angle   = 0;
  logic        [16:0] model_blend_weight = 17'd32768;
  logic        [15:0] model_gyro_gain    = 16'd4588;

  // results still owed by the block, oldest first
  tilt_result_t       expected_angles[$];
  tilt_result_t       head_result;
  int                 errors             = 0;
  bit                 idling_on          = 1'b1;
  int                 pop_stall          = 0;

  // atan(2^-i) in 1/65536 degree
  longint atan_step_q16 [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  tilt_complementary_filter i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_gyro_rate_raw   (in_gyro_rate_raw),
    .in_accel_x_raw     (in_accel_x_raw),
    .in_accel_z_raw     (in_accel_z_raw),
    .in_step_time_us    (in_step_time_us),
    .empty              (empty),
    .pop                (pop),
    .out_filtered_angle (out_filtered_angle),
    .out_accel_angle    (out_accel_angle),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

  // accelerometer angle in 1/256 degree from a vectoring cordic
  function automatic logic [16:0] accel_tilt_angle(input logic signed [15:0] ax_raw,
                                                   input logic signed [15:0] az_raw);
    longint ax, az, x, y, z, base, total, xs, ys;
    ax = ax_raw;
    az = az_raw;
    z  = 0;
    // no direction at all: atan2 taken as zero, i.e. 180 degrees
    if (ax == 0 && az == 0) return 17'(tcf_pkg::ACC_ZERO_ANGLE);
    // left half plane is mirrored through the origin, base picks the quadrant
    if (ax < 0) begin
      x    = -ax * 16384;
      y    = -az * 16384;
      base = (az >= 0) ? 360 * 65536 : 0;
    end else begin
      x    = ax * 16384;
      y    = az * 16384;
      base = 180 * 65536;
    end
    for (int i = 0; i < tcf_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step_q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step_q16[i];
      end
    end
    // cordic residue can step just outside 0..360 degrees
    total = base + z;
    if (total < 0) total = 0;
    if (total > tcf_pkg::ACC_MAX_Q16) total = tcf_pkg::ACC_MAX_Q16;
    return 17'((total + 128) >>> 8);
  endfunction

  // advance the model by one sample and queue the result it owes
  task automatic predict_tilt(input logic signed [15:0] gyro, input logic signed [15:0] ax,
                              input logic signed [15:0] az, input logic [15:0] dt);
    longint       acc, num, mag, delta, pred, weight, blended, res;
    tilt_result_t r;
    acc = accel_tilt_angle(ax, az);
    // gyro increment, rounded to nearest with halves away from zero
    num   = longint'(gyro) * longint'(model_gyro_gain) * longint'(dt);
    mag   = (num < 0) ? -num : num;
    delta = (mag + 128000000) / 256000000;
    if (num < 0) delta = -delta;
    pred = model_kept_angle + delta;
    // weights above one act as one
    weight  = (model_blend_weight > tcf_pkg::ONE_Q16) ? tcf_pkg::ONE_Q16 :
              longint'(model_blend_weight);
    blended = weight * pred + (tcf_pkg::ONE_Q16 - weight) * acc;
    res     = (blended + 32768) >>> 16;
    if (res > tcf_pkg::ANGLE_LIMIT) res = tcf_pkg::ANGLE_LIMIT;
    if (res < -tcf_pkg::ANGLE_LIMIT) res = -tcf_pkg::ANGLE_LIMIT;
    model_kept_angle = res;
    r.filtered_angle = 19'(res);
    r.accel_angle    = 17'(acc);
    expected_angles.push_back(r);
  endtask

  // send one request; push stays high unless an idle burst follows
  task automatic send_request(input logic signed [15:0] gyro, input logic signed [15:0] ax,
                              input logic signed [15:0] az, input logic [15:0] dt);
    push             <= 1'b1;
    in_gyro_rate_raw <= gyro;
    in_accel_x_raw   <= ax;
    in_accel_z_raw   <= az;
    in_step_time_us  <= dt;
    do @(posedge clk); while (full);
    predict_tilt(gyro, ax, az, dt);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // random 16-bit field, weighted toward the corners
  function automatic logic [15:0] random_word();
    logic [15:0] w;
    case ($urandom_range(0, 9))
      0:       w = 16'h8000;
      1:       w = 16'h7fff;
      2:       w = 16'h0000;
      3:       w = 16'hffff;
      4:       w = 16'($urandom_range(0, 15));
      5:       w = 16'h0000 - 16'($urandom_range(1, 16));
      default: w = 16'($urandom);
    endcase
    return w;
  endfunction

  task automatic send_random_request();
    logic [15:0] dt;
    dt = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2000)) : 16'($urandom);
    send_request(random_word(), random_word(), random_word(), dt);
  endtask

  // drop push, wait for every owed result, then let the back end go quiet
  task automatic settle_block();
    push <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [tcf_pkg::CFG_IDX_W-1:0] idx,
                                input logic [16:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == tcf_pkg::REG_BLEND_WEIGHT) model_blend_weight = value;
    else model_gyro_gain = value[15:0];
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [16:0] blend, input logic [15:0] gain);
    settle_block();
    write_register(tcf_pkg::REG_BLEND_WEIGHT, blend);
    write_register(tcf_pkg::REG_GYRO_GAIN, {1'b0, gain});
  endtask

  // reset register values, zero and corner accelerometer inputs
  task automatic test_reset_defaults();
    send_request(16'sd0, 16'sd0, 16'sd0, 16'd0);
    send_request(16'sd0, -16'sd32768, 16'sd0, 16'd0);
    send_request(16'sd32767, 16'sd32767, 16'sd32767, 16'd65535);
    send_request(-16'sd32768, -16'sd32768, -16'sd1, 16'd65535);
    send_request(-16'sd1, 16'sd1, -16'sd32768, 16'd1);
  endtask

  // pure accelerometer path: the 90, 180, 270 and 360 degree directions and two diagonals
  task automatic test_accel_quadrants();
    apply_settings(17'd0, 16'd4588);
    send_request(16'sd0, 16'sd32767, 16'sd0, 16'd100);
    send_request(16'sd0, 16'sd0, 16'sd32767, 16'd100);
    send_request(16'sd0, 16'sd0, -16'sd32768, 16'd100);
    send_request(16'sd0, -16'sd1, 16'sd0, 16'd100);
    send_request(16'sd0, -16'sd32768, 16'sd32767, 16'd100);
    send_request(16'sd0, 16'sd1, 16'sd1, 16'd100);
  endtask

  // full gyro weight and largest increments drive the angle into its limits
  task automatic test_gyro_saturation();
    apply_settings(17'd65536, 16'd65535);
    send_request(16'sd32767, 16'sd0, 16'sd0, 16'd65535);
    send_request(16'sd32767, 16'sd0, 16'sd0, 16'd65535);
    send_request(-16'sd32768, 16'sd5, 16'sd5, 16'd65535);
    send_request(-16'sd32768, 16'sd5, 16'sd5, 16'd65535);
    // weight register beyond one is clipped to one
    apply_settings(17'd131071, 16'd65535);
    send_request(16'sd32767, -16'sd32768, -16'sd32768, 16'd65535);
    send_request(-16'sd32768, 16'sd32767, -16'sd32768, 16'd65535);
  endtask

  // no gyro contribution at all, nearly no kept angle weight
  task automatic test_zero_gain();
    apply_settings(17'd1, 16'd0);
    send_request(16'sd32767, 16'sd100, -16'sd200, 16'd65535);
    send_request(-16'sd32768, -16'sd300, 16'sd400, 16'd65535);
  endtask

  // random requests under a spread of register settings
  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       apply_settings(17'd0, 16'd65535);
        1:       apply_settings(17'd65536, 16'd0);
        2:       apply_settings(17'd65535, 16'd65535);
        3:       apply_settings(17'($urandom_range(0, 131071)), 16'($urandom));
        4:       apply_settings(17'($urandom_range(0, 65536)), 16'($urandom));
        default: apply_settings(17'd131071, 16'($urandom));
      endcase
      repeat (ITEMS_PER_PHASE) send_random_request();
    end
  endtask

  // back-to-back traffic with no stalls on either side
  task automatic test_steady_flow();
    apply_settings(17'($urandom_range(0, 65536)), 16'd4588);
    idling_on = 1'b0;
    repeat (ITEMS_PER_PHASE) send_random_request();
  endtask

  // result side: compare each popped result, then pick the next pop level
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_angles.size() == 0) begin
          $display("%0t unexpected result: filtered_angle %0d accel_angle %0d",
                   $time, out_filtered_angle, out_accel_angle);
          errors++;
        end else begin
          head_result = expected_angles.pop_front();
          if (out_filtered_angle !== head_result.filtered_angle) begin
            $display("%0t filtered_angle mismatch: expected %0d actual %0d",
                     $time, head_result.filtered_angle, out_filtered_angle);
            errors++;
          end
          if (out_accel_angle !== head_result.accel_angle) begin
            $display("%0t accel_angle mismatch: expected %0d actual %0d",
                     $time, head_result.accel_angle, out_accel_angle);
            errors++;
          end
        end
      end
      // random pop stall bursts
      if (pop_stall > 0) begin
        pop <= 1'b0;
        pop_stall--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        pop_stall = $urandom_range(0, 6);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int waited;
    waited = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_accel_quadrants();
    test_gyro_saturation();
    test_zero_gain();
    test_random_settings();
    test_steady_flow();

    // drain whatever is still owed, bounded
    push <= 1'b0;
    while (expected_angles.size() != 0 && waited < END_WAIT_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_angles.size() != 0) begin
      $display("%0t %0d results never arrived", $time, expected_angles.size());
      errors++;
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
